FILE: hdl/crse_pkg.sv
package crse_pkg;
  localparam int FuncW = 3;
  localparam int CoordW = 8;
  localparam int RadW = 7;
  localparam int GlyphW = 8;
  localparam int CfgW = 7;
  localparam int CfgIdxW = 1;
  localparam logic [GlyphW-1:0] BlankCell = 8'd32;

  localparam logic [FuncW-1:0] FUNC_CLEAR = 3'd0;
  localparam logic [FuncW-1:0] FUNC_POINT = 3'd1;
  localparam logic [FuncW-1:0] FUNC_RING  = 3'd2;
  localparam logic [FuncW-1:0] FUNC_DISC  = 3'd3;
  localparam logic [FuncW-1:0] FUNC_LINE  = 3'd4;
  localparam logic [FuncW-1:0] FUNC_RECTO = 3'd5;
  localparam logic [FuncW-1:0] FUNC_RECTF = 3'd6;
  localparam logic [FuncW-1:0] FUNC_READ  = 3'd7;

  localparam logic [CfgIdxW-1:0] REG_WIDTH  = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_HEIGHT = 1'd1;

  typedef struct packed {
    logic [FuncW-1:0] func;
    logic signed [CoordW-1:0] row_a;
    logic signed [CoordW-1:0] col_a;
    logic signed [CoordW-1:0] row_b;
    logic signed [CoordW-1:0] col_b;
    logic [RadW-1:0] radius;
    logic [GlyphW-1:0] glyph;
  } cmd_t;

  typedef struct packed {
    logic [GlyphW-1:0] read_value;
  } rsp_t;
endpackage

FILE: hdl/crse_if.sv
interface crse_if #(
  parameter type payload_t = logic
);
  logic valid;
  logic ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: hdl/crse_frame_mem.sv
module crse_frame_mem #(
  parameter int Depth = 4096,
  parameter int AddrW = 12
) (
  input  logic clk,
  input  logic wr_en,
  input  logic [AddrW-1:0] wr_addr,
  input  logic [crse_pkg::GlyphW-1:0] wr_data,
  input  logic [AddrW-1:0] rd_addr,
  output logic [crse_pkg::GlyphW-1:0] rd_data
);
  import crse_pkg::*;
  logic [GlyphW-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

FILE: hdl/char_raster_shape_engine.sv
// Character raster shape engine.
// The cmd channel carries one drawing or read command per beat; the rsp
// channel returns exactly one beat per command, holding the cell character
// for a read inside the grid and zero otherwise. Configuration writes set grid_width
// (index 0) and grid_height (index 1). They take effect at once, so they
// belong only in gaps where no command is in flight.
// The frame lives in a single byte memory with one write and one registered
// read port, addressed as {row, col}.
// After reset the block first sweeps every memory address to space, one cell
// a cycle, and takes no command meanwhile.
// A point command writes its cell in state READ and offers its beat from
// DONE; a read passes through READ, RDATA (the registered memory read) and
// DONE. Every other command walks all memory addresses, one per cycle, through
// a two-stage pipeline (address, then hit test and write), then passes through
// RDATA and DONE before it offers its beat.
// The response sits in an output register, and a new command is accepted
// only after that register has been emptied, so a stalled receiver holds the
// block idle.
module char_raster_shape_engine #(
  parameter int MAX_WIDTH = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic clk,
  input  logic rst,
  crse_if.sink cmd,
  crse_if.source rsp,
  input  logic cfg_we,
  input  logic [crse_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [crse_pkg::CfgW-1:0] cfg_data
);
  import crse_pkg::*;

  localparam int ColW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RowW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int AddrW = ColW + RowW;
  localparam int Depth = 1 << AddrW;
  localparam int ColLast = (1 << ColW) - 1;
  localparam int RowLast = (1 << RowW) - 1;

  localparam logic [2:0] ST_INIT = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_SWEEP = 3'd2;
  localparam logic [2:0] ST_READ = 3'd3;
  localparam logic [2:0] ST_RDATA = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0] state;
  logic [CfgW-1:0] grid_width, grid_height;
  cmd_t cur;
  logic [ColW-1:0] col;
  logic [RowW-1:0] row;
  logic last_cell;

  // Second pipeline stage of the sweep.
  logic s1_valid;
  logic [ColW-1:0] s1_col;
  logic [RowW-1:0] s1_row;

  logic out_valid;
  logic [GlyphW-1:0] out_data;

  logic wr_en;
  logic [AddrW-1:0] wr_addr, rd_addr;
  logic [GlyphW-1:0] wr_data, rd_data;

  // Saturated size in use, one bit wider than coordinates.
  logic [8:0] cols_used, rows_used;
  always_comb begin
    cols_used = (9'(grid_width) > 9'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : 9'(grid_width);
    rows_used = (9'(grid_height) > 9'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : 9'(grid_height);
  end

  crse_frame_mem #(.Depth(Depth), .AddrW(AddrW)) u_mem (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_addr(rd_addr), .rd_data(rd_data)
  );

  assign rd_addr = {RowW'(cur.row_a), ColW'(cur.col_a)};
  assign last_cell = (col == ColW'(ColLast)) && (row == RowW'(RowLast));

  // Signed point test for the command's start point.
  logic a_in_grid;
  always_comb begin
    a_in_grid = !cur.row_a[CoordW-1] && !cur.col_a[CoordW-1] &&
                (9'(unsigned'(cur.row_a)) < rows_used) &&
                (9'(unsigned'(cur.col_a)) < cols_used);
  end

  // Hit test for the cell held in stage 1.
  logic signed [9:0] dr, dc, rr, cc;
  logic signed [18:0] sq_r, sq_c;
  logic signed [19:0] sq_dist;
  logic [13:0] rad_sq;
  logic cell_used, in_box, on_edge, line_hit, hit;
  logic signed [17:0] lprod, lnum, lquo_lo, lquo_hi;
  logic signed [9:0] dcol, drow;
  always_comb begin
    rr = 10'(s1_row);
    cc = 10'(s1_col);
    dr = rr - 10'(cur.row_a);
    dc = cc - 10'(cur.col_a);
    sq_r = 19'(dr * dr);
    sq_c = 19'(dc * dc);
    rad_sq = 14'(cur.radius) * 14'(cur.radius);
    sq_dist = 20'(sq_r) + 20'(sq_c) - 20'(signed'({1'b0, rad_sq}));
    cell_used = (9'(s1_row) < rows_used) && (9'(s1_col) < cols_used);
    in_box = (rr >= 10'(cur.row_a)) && (rr <= 10'(cur.row_b)) &&
             (cc >= 10'(cur.col_a)) && (cc <= 10'(cur.col_b));
    on_edge = (rr == 10'(cur.row_a)) || (rr == 10'(cur.row_b)) ||
              (cc == 10'(cur.col_a)) || (cc == 10'(cur.col_b));
    // Line: row - ra == floor(drow*dc/dcol)  <=>
    // dcol*(row-ra) <= drow*dc < dcol*(row-ra+1), with dcol > 0.
    // A line with equal columns plots only its start cell.
    dcol = 10'(cur.col_b) - 10'(cur.col_a);
    drow = 10'(cur.row_b) - 10'(cur.row_a);
    lnum = 18'(drow * dc);
    lprod = 18'(dcol * dr);
    lquo_lo = lprod;
    lquo_hi = lprod + 18'(dcol);
    line_hit = ((dcol > 0) && (dc >= 0) && (cc <= 10'(cur.col_b)) &&
                (lnum >= lquo_lo) && (lnum < lquo_hi)) ||
               ((dcol == 10'sd0) && (dr == 10'sd0) && (dc == 10'sd0));
    case (cur.func)
      FUNC_RING:  hit = (sq_dist >= -20'sd2) && (sq_dist <= 20'sd2);
      FUNC_DISC:  hit = (sq_dist <= 20'sd0);
      FUNC_LINE:  hit = line_hit;
      FUNC_RECTO: hit = in_box && on_edge;
      FUNC_RECTF: hit = in_box;
      default:    hit = 1'b1;
    endcase
  end

  always_comb begin
    wr_en = 1'b0;
    wr_addr = {s1_row, s1_col};
    wr_data = cur.glyph;
    if (state == ST_INIT) begin
      wr_en = 1'b1;
      wr_addr = {row, col};
      wr_data = BlankCell;
    end else if (s1_valid) begin
      wr_en = cell_used && hit;
      wr_data = (cur.func == FUNC_CLEAR) ? BlankCell : cur.glyph;
    end else if (state == ST_READ && cur.func == FUNC_POINT) begin
      wr_en = a_in_grid;
      wr_addr = rd_addr;
    end
  end

  assign cmd.ready = (state == ST_IDLE) && !out_valid;
  assign rsp.valid = out_valid;
  assign rsp.payload.read_value = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
      grid_width <= CfgW'(64);
      grid_height <= CfgW'(64);
      row <= '0;
      col <= '0;
      s1_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_WIDTH:  grid_width <= cfg_data;
          REG_HEIGHT: grid_height <= cfg_data;
          default: ;
        endcase
      end
      if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      s1_valid <= 1'b0;
      unique case (state)
        ST_INIT: begin
          {row, col} <= {row, col} + AddrW'(1);
          if (last_cell) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (cmd.valid && cmd.ready) begin
            cur <= cmd.payload;
            row <= '0;
            col <= '0;
            if (cmd.payload.func == FUNC_POINT || cmd.payload.func == FUNC_READ) begin
              state <= ST_READ;
            end else begin
              state <= ST_SWEEP;
            end
          end
        end
        ST_SWEEP: begin
          s1_valid <= 1'b1;
          s1_row <= row;
          s1_col <= col;
          {row, col} <= {row, col} + AddrW'(1);
          if (last_cell) begin
            state <= ST_RDATA;
          end
        end
        ST_READ: begin
          state <= (cur.func == FUNC_READ) ? ST_RDATA : ST_DONE;
        end
        ST_RDATA: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          out_valid <= 1'b1;
          out_data <= (cur.func == FUNC_READ && a_in_grid) ? rd_data : '0;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule

FILE: tb/sv/tb_char_raster_shape_engine.sv
`timescale 1ns / 1ps

// Testbench for the character raster shape engine.
// Commands go in on the cmd channel and each one returns exactly one beat on
// the rsp channel. A behavioral copy of the frame buffer and of the two size
// registers predicts every response. Shape commands write only, so they are
// observed through later read commands. Shape and clear commands sweep the
// whole buffer, so the random mix leans on cheap point and read commands.
module tb_char_raster_shape_engine;
  import crse_pkg::*;

  localparam int MaxCols = 64;
  localparam int MaxRows = 64;
  localparam int CycleLimit = 3000000;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgW-1:0] cfg_data;

  crse_if #(.payload_t(cmd_t)) cmd_ch ();
  crse_if #(.payload_t(rsp_t)) rsp_ch ();

  char_raster_shape_engine #(
    .MAX_WIDTH(MaxCols),
    .MAX_HEIGHT(MaxRows)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .rsp(rsp_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Shadow copy of the frame and of the size registers.
  logic [GlyphW-1:0] shadow_frame [0:MaxCols*MaxRows-1];
  int unsigned shadow_width;
  int unsigned shadow_height;

  // Read values still owed by the block, oldest first.
  logic [GlyphW-1:0] owed_values[$];

  int err_count;
  int cycle_count;
  int idle_pct;
  int stall_pct;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // The watchdog covers the reset sweep and the slowest legal run many times.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("char_raster_shape_engine: mismatch");
      $finish;
    end
  end

  // The receiver stalls at random on each falling edge.
  always @(negedge clk) begin
    rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Every rsp beat is compared with the oldest owed value.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (owed_values.size() == 0) begin
        err_count++;
        $display("%0t: unexpected beat, expected none, actual %0d",
                 $time, rsp_ch.payload.read_value);
      end else begin
        if (rsp_ch.payload.read_value !== owed_values[0]) begin
          err_count++;
          $display("%0t: read_value expected %0d, actual %0d",
                   $time, owed_values[0], rsp_ch.payload.read_value);
        end
        void'(owed_values.pop_front());
      end
    end
  end

  function automatic int cols_in_use();
    return (shadow_width > MaxCols) ? MaxCols : int'(shadow_width);
  endfunction

  function automatic int rows_in_use();
    return (shadow_height > MaxRows) ? MaxRows : int'(shadow_height);
  endfunction

  function automatic bit on_grid(int r, int c);
    return r >= 0 && c >= 0 && r < rows_in_use() && c < cols_in_use();
  endfunction

  function automatic void paint_cell(int r, int c, logic [GlyphW-1:0] g);
    if (on_grid(r, c)) shadow_frame[r*MaxCols + c] = g;
  endfunction

  // Floor division for a positive divisor.
  function automatic int floor_quot(int n, int d);
    if (n >= 0) return n / d;
    return -((-n + d - 1) / d);
  endfunction

  // Applies one command to the shadow frame and returns its read value.
  function automatic logic [GlyphW-1:0] draw_and_read(cmd_t cm);
    int ra, ca, rb, cb, rad, sq_dist, dcol, drow;
    bit hit;
    logic [GlyphW-1:0] value;
    ra = int'(cm.row_a);
    ca = int'(cm.col_a);
    rb = int'(cm.row_b);
    cb = int'(cm.col_b);
    rad = int'(cm.radius);
    value = '0;
    case (cm.func)
      FUNC_CLEAR: begin
        for (int r = 0; r < rows_in_use(); r++)
          for (int c = 0; c < cols_in_use(); c++) shadow_frame[r*MaxCols + c] = BlankCell;
      end
      FUNC_POINT: paint_cell(ra, ca, cm.glyph);
      FUNC_RING, FUNC_DISC: begin
        for (int r = 0; r < rows_in_use(); r++)
          for (int c = 0; c < cols_in_use(); c++) begin
            sq_dist = (r - ra) * (r - ra) + (c - ca) * (c - ca) - rad * rad;
            hit = (cm.func == FUNC_RING) ? (sq_dist >= -2 && sq_dist <= 2) : (sq_dist <= 0);
            if (hit) shadow_frame[r*MaxCols + c] = cm.glyph;
          end
      end
      FUNC_LINE: begin
        dcol = cb - ca;
        drow = rb - ra;
        // Equal columns plot only the start; a leftward line draws nothing.
        if (dcol == 0) begin
          paint_cell(ra, ca, cm.glyph);
        end else if (dcol > 0) begin
          for (int c = ca; c <= cb; c++)
            paint_cell(ra + floor_quot(drow * (c - ca), dcol), c, cm.glyph);
        end
      end
      FUNC_RECTO, FUNC_RECTF: begin
        for (int r = 0; r < rows_in_use(); r++)
          for (int c = 0; c < cols_in_use(); c++) begin
            if (r < ra || r > rb || c < ca || c > cb) continue;
            if (cm.func == FUNC_RECTF || r == ra || r == rb || c == ca || c == cb)
              shadow_frame[r*MaxCols + c] = cm.glyph;
          end
      end
      default: begin
        if (on_grid(ra, ca)) value = shadow_frame[ra*MaxCols + ca];
      end
    endcase
    return value;
  endfunction

  // Sends one command beat. Valid stays high into the next call, so it is
  // lowered only when the sender idles or a drain runs.
  task automatic send_cmd(cmd_t cm);
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      cmd_ch.valid <= 1'b0;
    end
    @(negedge clk);
    cmd_ch.valid <= 1'b1;
    cmd_ch.payload <= cm;
    do @(posedge clk); while (!cmd_ch.ready);
    owed_values.push_back(draw_and_read(cm));
  endtask

  task automatic make_cmd(output cmd_t cm, input logic [FuncW-1:0] f,
                          input int ra, input int ca, input int rb, input int cb,
                          input int rad, input int g);
    cm.func = f;
    cm.row_a = ra[CoordW-1:0];
    cm.col_a = ca[CoordW-1:0];
    cm.row_b = rb[CoordW-1:0];
    cm.col_b = cb[CoordW-1:0];
    cm.radius = rad[RadW-1:0];
    cm.glyph = g[GlyphW-1:0];
  endtask

  task automatic issue(logic [FuncW-1:0] f, int ra, int ca, int rb, int cb,
                       int rad, int g);
    cmd_t cm;
    make_cmd(cm, f, ra, ca, rb, cb, rad, g);
    send_cmd(cm);
  endtask

  // Lowers valid and waits until every owed beat has arrived.
  task automatic drain();
    @(negedge clk);
    cmd_ch.valid <= 1'b0;
    while (owed_values.size() != 0) @(posedge clk);
  endtask

  // Register writes happen only while the block is idle.
  task automatic write_size(logic [CfgIdxW-1:0] idx, int value);
    drain();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CfgW-1:0];
    if (idx == REG_WIDTH) shadow_width = value & 'h7f;
    else shadow_height = value & 'h7f;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic test_reset_state();
    issue(FUNC_READ, 0, 0, 0, 0, 0, 0);
    issue(FUNC_READ, 63, 63, 0, 0, 0, 0);
    issue(FUNC_READ, -128, 127, 0, 0, 0, 0);
  endtask

  // Points at two corners and outside the grid; the corners are read back.
  task automatic test_points();
    issue(FUNC_POINT, 0, 0, 0, 0, 0, 255);
    issue(FUNC_POINT, 63, 63, 0, 0, 0, 0);
    issue(FUNC_POINT, 64, 0, 0, 0, 0, 170);
    issue(FUNC_POINT, -1, 127, 0, 0, 0, 85);
    issue(FUNC_READ, 0, 0, 0, 0, 0, 0);
    issue(FUNC_READ, 63, 63, 0, 0, 0, 0);
  endtask

  // Each shape at least once, including a degenerate line and an empty rectangle.
  task automatic test_shapes();
    issue(FUNC_RING, 20, 20, 0, 0, 10, 111);
    issue(FUNC_DISC, 50, 10, 0, 0, 4, 66);
    issue(FUNC_LINE, 5, 5, 40, 60, 0, 76);
    issue(FUNC_LINE, 10, 30, 127, 30, 0, 77);
    issue(FUNC_LINE, 10, 30, 12, 20, 0, 78);
    issue(FUNC_RECTO, 30, 30, 40, 50, 0, 79);
    issue(FUNC_RECTF, 40, 40, 30, 50, 0, 80);
    issue(FUNC_RECTF, -128, -128, 127, 127, 127, 33);
    issue(FUNC_READ, 10, 20, 0, 0, 0, 0);
    issue(FUNC_CLEAR, 0, 0, 0, 0, 0, 0);
    issue(FUNC_READ, 10, 20, 0, 0, 0, 0);
  endtask

  // A zero-size grid writes nothing and reads zero; larger values saturate.
  task automatic test_grid_sizes();
    write_size(REG_WIDTH, 0);
    write_size(REG_HEIGHT, 127);
    issue(FUNC_POINT, 1, 1, 0, 0, 0, 99);
    issue(FUNC_READ, 1, 1, 0, 0, 0, 0);
    write_size(REG_WIDTH, 1);
    write_size(REG_HEIGHT, 1);
    issue(FUNC_RECTF, 0, 0, 5, 5, 0, 7);
    issue(FUNC_READ, 0, 0, 0, 0, 0, 0);
    write_size(REG_WIDTH, 64);
    write_size(REG_HEIGHT, 64);
    issue(FUNC_READ, 1, 1, 0, 0, 0, 0);
  endtask

  function automatic int near_coord(int span);
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 255) - 128;
    return $urandom_range(0, span + 8) - 4;
  endfunction

  // Random commands under one idling setting. Sweeping shapes are kept to
  // about a third of the mix; the rest are mostly points and reads near the grid.
  task automatic test_random_phase(int sender_idle, int receiver_stall, int count);
    cmd_t cm;
    int pick;
    idle_pct = sender_idle;
    stall_pct = receiver_stall;
    if ($urandom_range(0, 3) == 0) begin
      write_size(REG_WIDTH, $urandom_range(0, 127));
      write_size(REG_HEIGHT, $urandom_range(0, 127));
    end else begin
      write_size(REG_WIDTH, $urandom_range(1, 64));
      write_size(REG_HEIGHT, $urandom_range(1, 64));
    end
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      make_cmd(cm, FUNC_READ, near_coord(MaxRows), near_coord(MaxCols),
               near_coord(MaxRows), near_coord(MaxCols),
               ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 30),
               $urandom_range(0, 255));
      if (pick < 40) cm.func = FUNC_READ;
      else if (pick < 65) cm.func = FUNC_POINT;
      else if (pick < 67) cm.func = FUNC_CLEAR;
      else cm.func = FuncW'($urandom_range(2, 6));
      send_cmd(cm);
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cmd_ch.valid = 1'b0;
    cmd_ch.payload = '0;
    rsp_ch.ready = 1'b0;
    err_count = 0;
    cycle_count = 0;
    idle_pct = 0;
    stall_pct = 0;
    shadow_width = 64;
    shadow_height = 64;
    for (int k = 0; k < MaxCols*MaxRows; k++) shadow_frame[k] = BlankCell;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    drain();
    test_points();
    test_shapes();
    test_grid_sizes();
    test_random_phase(0, 0, 29);
    test_random_phase(82, 0, 29);
    test_random_phase(0, 82, 29);
    test_random_phase(6, 6, 29);

    drain();
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("char_raster_shape_engine: match");
    end else begin
      $display("char_raster_shape_engine: mismatch");
    end
    $finish;
  end
endmodule
